/* hw/rtl/sha1_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_pkg
// shared types, constants and helpers of the sha-1 hash engine
// ----------------------------------------------------------------------------
package sha1_pkg;

    localparam int WORD_W     = 32;
    localparam int NB_W       = 3;
    localparam int IDX_W      = 3;
    localparam int BLK_WORDS  = 16;
    localparam int CNT_W      = 4;
    localparam int ROUNDS     = 80;
    localparam int ROUND_W    = 7;
    localparam int CHAIN_N    = 5;
    localparam int BYTES_W    = 61;

    localparam logic [WORD_W-1:0] H0_INIT = 32'h67452301;
    localparam logic [WORD_W-1:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] H2_INIT = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] H3_INIT = 32'h10325476;
    localparam logic [WORD_W-1:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [WORD_W-1:0] K_CH     = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_PAR1   = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_MAJ    = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_PAR2   = 32'hCA62C1D6;
    localparam logic [WORD_W-1:0] PAD_WORD = 32'h80000000;

    localparam logic [NB_W-1:0]  FULL_BYTES = 3'd4;
    localparam logic [IDX_W-1:0] LAST_INDEX = 3'd4;
    localparam logic [CNT_W-1:0] CNT_LEN    = 4'd14;
    localparam logic [CNT_W-1:0] CNT_FULL   = 4'd15;
    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

    typedef struct packed {
        logic [WORD_W-1:0] message_word;
        logic [NB_W-1:0]   valid_bytes;
        logic              final_word;
    } msg_t;

    typedef struct packed {
        logic [WORD_W-1:0] digest_word;
        logic [IDX_W-1:0]  digest_index;
        logic              digest_last;
    } digest_t;

    typedef enum logic [2:0] {
        PUSH_MSG    = 3'd0,
        PUSH_MARK   = 3'd1,
        PUSH_ZERO   = 3'd2,
        PUSH_LEN_HI = 3'd3,
        PUSH_LEN_LO = 3'd4
    } push_sel_t;

    typedef enum logic [1:0] {
        FN_CH   = 2'd0,
        FN_PAR1 = 2'd1,
        FN_MAJ  = 2'd2,
        FN_PAR2 = 2'd3
    } round_fn_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PAD   = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    typedef struct packed {
        logic              push;
        push_sel_t         push_sel;
        logic              load_vars;
        logic              round_en;
        round_fn_t         round_fn;
        logic              add_chain;
        logic              reinit;
        logic [IDX_W-1:0]  out_index;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]  word_count;
    } dp_status_t;

    // effective byte count: partial words only count on the final word
    function automatic logic [NB_W-1:0] eff_bytes(input msg_t m);
        eff_bytes = (!m.final_word || m.valid_bytes > FULL_BYTES) ? FULL_BYTES
                                                                 : m.valid_bytes;
    endfunction

    function automatic logic [WORD_W-1:0] keep_mask(input logic [NB_W-1:0] nb);
        unique case (nb)
            3'd0:    keep_mask = 32'h00000000;
            3'd1:    keep_mask = 32'hFF000000;
            3'd2:    keep_mask = 32'hFFFF0000;
            3'd3:    keep_mask = 32'hFFFFFF00;
            default: keep_mask = 32'hFFFFFFFF;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] pad_mark(input logic [NB_W-1:0] nb);
        unique case (nb)
            3'd0:    pad_mark = 32'h80000000;
            3'd1:    pad_mark = 32'h00800000;
            3'd2:    pad_mark = 32'h00008000;
            3'd3:    pad_mark = 32'h00000080;
            default: pad_mark = 32'h00000000;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input int unsigned n);
        rotl = (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

/* hw/rtl/sha1_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_datapath
// message schedule window, round variables, chaining words and length count
// ----------------------------------------------------------------------------
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  msg_t              msg,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    output logic [WORD_W-1:0] digest_word
);

    logic [WORD_W-1:0]  w_reg     [BLK_WORDS];
    logic [WORD_W-1:0]  w_next_in;
    logic [WORD_W-1:0]  var_reg   [CHAIN_N];
    logic [WORD_W-1:0]  chain_reg [CHAIN_N];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [BYTES_W-1:0] bytes_reg;
    logic [BYTES_W-1:0] bytes_next;
    logic [NB_W-1:0]    nb;
    logic [WORD_W-1:0]  push_val;
    logic [WORD_W-1:0]  f_val;
    logic [WORD_W-1:0]  k_val;
    logic [WORD_W-1:0]  temp_val;

    assign nb = eff_bytes(msg);

    always_comb
    begin
        unique case (cmd.push_sel)
            PUSH_MSG:    push_val = (msg.message_word & keep_mask(nb)) | pad_mark(nb);
            PUSH_MARK:   push_val = PAD_WORD;
            PUSH_LEN_HI: push_val = bytes_reg[BYTES_W-1:BYTES_W-WORD_W];
            PUSH_LEN_LO: push_val = {bytes_reg[WORD_W-4:0], 3'b000};
            default:     push_val = '0;
        endcase
    end

    // schedule expansion: w[t+16] from the sliding 16-word window
    assign w_next_in = rotl(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0], 1);

    always_comb
    begin
        unique case (cmd.round_fn)
            FN_CH:
            begin
                f_val = (var_reg[1] & var_reg[2]) | (~var_reg[1] & var_reg[3]);
                k_val = K_CH;
            end
            FN_PAR1:
            begin
                f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
                k_val = K_PAR1;
            end
            FN_MAJ:
            begin
                f_val = (var_reg[1] & var_reg[2]) | (var_reg[1] & var_reg[3])
                      | (var_reg[2] & var_reg[3]);
                k_val = K_MAJ;
            end
            default:
            begin
                f_val = var_reg[1] ^ var_reg[2] ^ var_reg[3];
                k_val = K_PAR2;
            end
        endcase
    end

    assign temp_val = rotl(var_reg[0], 5) + f_val + var_reg[4] + k_val + w_reg[0];

    // window shifts toward index 0 on both a push and a round
    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.round_en)
        begin
            for (int i = 0; i < BLK_WORDS - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BLK_WORDS-1] <= cmd.push ? push_val : w_next_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_vars)
        begin
            for (int i = 0; i < CHAIN_N; i++)
            begin
                var_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            var_reg[0] <= temp_val;
            var_reg[1] <= var_reg[0];
            var_reg[2] <= rotl(var_reg[1], 30);
            var_reg[3] <= var_reg[2];
            var_reg[4] <= var_reg[3];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        bytes_next = bytes_reg;
        if (cmd.reinit)
        begin
            count_next = '0;
            bytes_next = '0;
        end
        else
        begin
            if (cmd.push)
            begin
                count_next = count_reg + 1'b1;
            end
            if (cmd.push && cmd.push_sel == PUSH_MSG)
            begin
                bytes_next = bytes_reg + BYTES_W'(nb);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            bytes_reg    <= '0;
            chain_reg[0] <= H0_INIT;
            chain_reg[1] <= H1_INIT;
            chain_reg[2] <= H2_INIT;
            chain_reg[3] <= H3_INIT;
            chain_reg[4] <= H4_INIT;
        end
        else
        begin
            count_reg <= count_next;
            bytes_reg <= bytes_next;
            if (cmd.reinit)
            begin
                chain_reg[0] <= H0_INIT;
                chain_reg[1] <= H1_INIT;
                chain_reg[2] <= H2_INIT;
                chain_reg[3] <= H3_INIT;
                chain_reg[4] <= H4_INIT;
            end
            else if (cmd.add_chain)
            begin
                for (int i = 0; i < CHAIN_N; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + var_reg[i];
                end
            end
        end
    end

    always_comb
    begin
        unique case (cmd.out_index)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

    assign status.word_count = count_reg;

endmodule

/* hw/rtl/sha1_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_ctrl
// sequencer for word intake, padding, 80-round compression and digest output
// ----------------------------------------------------------------------------
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             msg_valid,
    output logic             msg_ready,
    input  msg_t             msg,
    output logic             digest_valid,
    input  logic             digest_ready,
    output logic [IDX_W-1:0] digest_index,
    output dp_cmd_t          cmd,
    input  dp_status_t       status
);

    state_t             state_reg,    state_next;
    logic [ROUND_W-1:0] round_reg,    round_next;
    logic [IDX_W-1:0]   index_reg,    index_next;
    logic               padding_reg,  padding_next;
    logic               mark_reg,     mark_next;
    logic               len_hi_reg,   len_hi_next;
    logic               pad_done_reg, pad_done_next;
    logic               block_full;

    assign block_full = (status.word_count == CNT_FULL);

    always_comb
    begin
        state_next    = state_reg;
        round_next    = round_reg;
        index_next    = index_reg;
        padding_next  = padding_reg;
        mark_next     = mark_reg;
        len_hi_next   = len_hi_reg;
        pad_done_next = pad_done_reg;

        cmd           = '0;
        cmd.push_sel  = PUSH_MSG;
        cmd.round_fn  = FN_CH;
        cmd.out_index = index_reg;

        msg_ready    = 1'b0;
        digest_valid = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_valid)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_sel  = PUSH_MSG;
                    cmd.load_vars = block_full;
                    if (msg.final_word)
                    begin
                        padding_next = 1'b1;
                        // a full final word leaves the pad byte for its own word
                        mark_next    = (eff_bytes(msg) == FULL_BYTES);
                    end
                    if (block_full)
                    begin
                        state_next = S_ROUND;
                        round_next = '0;
                    end
                    else if (msg.final_word)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                cmd.push      = 1'b1;
                cmd.load_vars = block_full;
                if (mark_reg)
                begin
                    cmd.push_sel = PUSH_MARK;
                    mark_next    = 1'b0;
                end
                else if (len_hi_reg)
                begin
                    cmd.push_sel  = PUSH_LEN_LO;
                    len_hi_next   = 1'b0;
                    pad_done_next = 1'b1;
                end
                else if (status.word_count == CNT_LEN)
                begin
                    cmd.push_sel = PUSH_LEN_HI;
                    len_hi_next  = 1'b1;
                end
                else
                begin
                    cmd.push_sel = PUSH_ZERO;
                end
                if (block_full)
                begin
                    state_next = S_ROUND;
                    round_next = '0;
                end
            end
            S_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (round_reg < 7'd20)
                begin
                    cmd.round_fn = FN_CH;
                end
                else if (round_reg < 7'd40)
                begin
                    cmd.round_fn = FN_PAR1;
                end
                else if (round_reg < 7'd60)
                begin
                    cmd.round_fn = FN_MAJ;
                end
                else
                begin
                    cmd.round_fn = FN_PAR2;
                end
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_LAST)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                cmd.add_chain = 1'b1;
                priority if (pad_done_reg)
                begin
                    state_next = S_OUT;
                    index_next = '0;
                end
                else if (padding_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OUT:
            begin
                digest_valid = 1'b1;
                if (digest_ready)
                begin
                    index_next = index_reg + 1'b1;
                    if (index_reg == LAST_INDEX)
                    begin
                        cmd.reinit    = 1'b1;
                        index_next    = '0;
                        padding_next  = 1'b0;
                        pad_done_next = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            round_reg    <= '0;
            index_reg    <= '0;
            padding_reg  <= 1'b0;
            mark_reg     <= 1'b0;
            len_hi_reg   <= 1'b0;
            pad_done_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            round_reg    <= round_next;
            index_reg    <= index_next;
            padding_reg  <= padding_next;
            mark_reg     <= mark_next;
            len_hi_reg   <= len_hi_next;
            pad_done_reg <= pad_done_next;
        end
    end

    assign digest_index = index_reg;

endmodule

/* hw/rtl/sha1_hash_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1_hash_engine
// streaming sha-1 over big-endian 32-bit words with in-line padding
// ----------------------------------------------------------------------------
// throughput: one word a cycle until a block fills, then intake waits for the
//   80 rounds and the chaining add
// after the final word, padding words go in one a cycle, then one or two
//   compressions of 80 rounds and a chaining add each, then five digest transactions
// reset: chaining words return to the initial values, counts clear; the engine
//   also returns to this state after the fifth digest word is taken
module sha1_hash_engine
    import sha1_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    msg_valid,
    output logic    msg_ready,
    input  msg_t    msg,
    output logic    digest_valid,
    input  logic    digest_ready,
    output digest_t digest
);

    dp_cmd_t           cmd;
    dp_status_t        status;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] word;

    sha1_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg          (msg),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_index (index),
        .cmd          (cmd),
        .status       (status)
    );

    sha1_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg         (msg),
        .cmd         (cmd),
        .status      (status),
        .digest_word (word)
    );

    assign digest.digest_word  = word;
    assign digest.digest_index = index;
    assign digest.digest_last  = (index == LAST_INDEX);

    // intake and digest output never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(msg_ready && digest_valid))
        else $error("intake and digest output active together");

    // after the last digest word the engine is ready for a new message
    a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && digest.digest_last) |=> msg_ready)
        else $error("engine not idle after last digest word");

    // digest words come out in order with no gaps
    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && !digest.digest_last) |=>
        (digest_valid && digest.digest_index == $past(digest.digest_index) + 3'd1))
        else $error("digest index did not advance");

    // intake stops once a word push fills the block
    a_ready_count: assert property (@(posedge clk) disable iff (!rst_n)
        (msg_valid && msg_ready && status.word_count == CNT_FULL) |=> !msg_ready)
        else $error("intake continued past a full block");

endmodule
